// ===== src/srpt_pkg.sv =====
package srpt_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int TM_W        = 16;
    localparam int QCNT_W      = 7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_RUN    = 1'b1;

    typedef struct packed {
        logic [TM_W-1:0] tm;
        logic [ID_W-1:0] id;
    } t_entry;

endpackage

// ===== src/srpt_sorted_priority_queue_top.sv =====
// Sorted job queue for shortest-remaining-processing-time scheduling. Each input transfer is
// one action: insert a job (tuser 0) or run the head job for one time unit (tuser 1). Jobs sit
// in one single-port-read, single-port-write memory sorted by remaining time, so one action is
// in flight at a time. An insert moves each entry with a larger time up one place and writes
// the new job behind them; a run that leaves time on the job rewrites the head in place, since
// the decremented head still sorts first; a run that finishes its job has the memory move the
// remaining entries down one per cycle; rejected actions go straight to the result. The head
// job is mirrored in registers. A result waiting at the output holds the block only once the
// next result is ready.
module srpt_sorted_priority_queue_top
    import srpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // job_id[7:0], remaining_time[23:8]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // ran_id[7:0], ran_time_before[23:8], head_id[31:24],
                                        // head_time[47:32], queue_count[54:48], zero[55]
    output logic [3:0]  m_axis_tuser    // ran_valid[0], finished[1], status[3:2]
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_SH      = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_mem_q;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_pos, n_pos;
    t_entry            r_item, n_item;
    t_entry            r_head;
    logic              r_ran_valid, n_ran_valid;
    logic              r_fin, n_fin;
    t_entry            r_ran, n_ran;
    logic [1:0]        r_status, n_status;

    logic              r_ovalid;
    logic [55:0]       r_otdata;
    logic [3:0]        r_otuser;

    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    t_entry            w_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    t_entry            in_item;
    logic              in_fire;
    logic              out_free;
    t_entry            head_out;

    assign in_item.id   = s_axis_tdata[7:0];
    assign in_item.tm   = s_axis_tdata[23:8];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire      = s_axis_tvalid && s_axis_tready;
    assign out_free     = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_item      = r_item;
        n_ran_valid = r_ran_valid;
        n_fin       = r_fin;
        n_ran       = r_ran;
        n_status    = r_status;
        w_en        = 1'b0;
        w_addr      = '0;
        w_data      = r_item;
        rd_en       = 1'b0;
        rd_addr     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_ran_valid = 1'b0;
                    n_fin       = 1'b0;
                    n_ran       = '0;
                    n_status    = ST_OK;
                    n_item      = in_item;
                    n_state     = S_DONE;
                    if (s_axis_tuser == ACT_INSERT) begin
                        if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (in_item.tm == '0) begin
                            n_status = ST_ZERO;
                        end else begin
                            n_pos   = r_count[ADDR_W-1:0];
                            n_count = r_count + CNT_W'(1);
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_ran_valid = 1'b1;
                            n_ran       = r_head;
                            if (r_head.tm > TM_W'(1)) begin
                                w_en      = 1'b1;
                                w_addr    = '0;
                                w_data.id = r_head.id;
                                w_data.tm = r_head.tm - TM_W'(1);
                            end else begin
                                n_fin   = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                if (r_count > CNT_W'(1)) begin
                                    rd_en   = 1'b1;
                                    rd_addr = ADDR_W'(1);
                                    n_pos   = ADDR_W'(1);
                                    n_state = S_SH;
                                end
                            end
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    w_en    = 1'b1;
                    w_addr  = '0;
                    w_data  = r_item;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos - ADDR_W'(1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (r_mem_q.tm > r_item.tm) begin
                    w_en   = 1'b1;
                    w_addr = r_pos;
                    w_data = r_mem_q;
                    n_pos  = r_pos - ADDR_W'(1);
                    if (r_pos == ADDR_W'(1)) begin
                        n_state = S_INS_RD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_pos - ADDR_W'(2);
                    end
                end else begin
                    w_en    = 1'b1;
                    w_addr  = r_pos;
                    w_data  = r_item;
                    n_state = S_DONE;
                end
            end
            S_SH: begin
                w_en   = 1'b1;
                w_addr = r_pos - ADDR_W'(1);
                w_data = r_mem_q;
                if (CNT_W'(r_pos) < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos + ADDR_W'(1);
                    n_pos   = r_pos + ADDR_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // job store
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_item      <= n_item;
        r_ran_valid <= n_ran_valid;
        r_fin       <= n_fin;
        r_ran       <= n_ran;
        r_status    <= n_status;
        // head mirror follows every write to the front entry
        if (w_en && w_addr == '0) begin
            r_head <= w_data;
        end
    end

    assign head_out = (r_count == '0) ? '0 : r_head;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_otdata <= {1'b0, QCNT_W'(r_count), head_out.tm, head_out.id, r_ran.tm, r_ran.id};
            r_otuser <= {r_status, r_fin, r_ran_valid};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_otuser;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import srpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 400;
    localparam int MIX_ITEMS   = 40;
    localparam int DIR_ROWS    = 20;

    typedef struct packed {
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic [TM_W-1:0]   ran_before;
        logic              finished;
        logic [ID_W-1:0]   head_id;
        logic [TM_W-1:0]   head_time;
        logic [QCNT_W-1:0] count;
        logic [1:0]        status;
    } step_result_t;

    typedef struct packed {
        logic            act;
        logic [ID_W-1:0] id;
        logic [TM_W-1:0] tm;
        logic            fixed_exp;
        step_result_t    res;
    } dir_row_t;

    typedef enum logic [1:0] {MODE_MIX, MODE_FILL, MODE_DRAIN} stim_mode_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // job_id[7:0], remaining_time[23:8]
    logic        s_axis_tuser  = 1'b0;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // ran_id[7:0], ran_time_before[23:8], head_id[31:24],
                                        // head_time[47:32], queue_count[54:48], zero[55]
    logic [3:0]  m_axis_tuser;          // ran_valid[0], finished[1], status[3:2]

    t_entry       job_queue[$];
    step_result_t awaited_results[$];

    int errors          = 0;
    int actions_sent    = 0;
    int results_checked = 0;
    int full_rejects    = 0;
    int empty_rejects   = 0;
    int zero_rejects    = 0;
    int jobs_finished   = 0;
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int holds_asked     = 0;
    int holds_done      = 0;
    int cycle_count     = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ACT_RUN,    8'h00, 16'h0000, 1'b1,
          '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 7'd0, ST_EMPTY}},
        '{ACT_INSERT, 8'h12, 16'h0000, 1'b1,
          '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 7'd0, ST_ZERO}},
        '{ACT_INSERT, 8'hFF, 16'hFFFF, 1'b1,
          '{1'b0, 8'h00, 16'h0000, 1'b0, 8'hFF, 16'hFFFF, 7'd1, ST_OK}},
        '{ACT_INSERT, 8'h00, 16'h0001, 1'b1,
          '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0001, 7'd2, ST_OK}},
        // tie: goes behind the job already holding time 1
        '{ACT_INSERT, 8'hA5, 16'h0001, 1'b1,
          '{1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0001, 7'd3, ST_OK}},
        '{ACT_RUN,    8'hFF, 16'hFFFF, 1'b1,
          '{1'b1, 8'h00, 16'h0001, 1'b1, 8'hA5, 16'h0001, 7'd2, ST_OK}},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b1,
          '{1'b1, 8'hA5, 16'h0001, 1'b1, 8'hFF, 16'hFFFF, 7'd1, ST_OK}},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b1,
          '{1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'hFF, 16'hFFFE, 7'd1, ST_OK}},
        '{ACT_INSERT, 8'h5A, 16'h8000, 1'b0, '0},
        '{ACT_INSERT, 8'h3C, 16'h0002, 1'b0, '0},
        '{ACT_INSERT, 8'hC3, 16'h0002, 1'b0, '0},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b0, '0},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b0, '0},
        '{ACT_INSERT, 8'h01, 16'hFFFF, 1'b0, '0},
        '{ACT_INSERT, 8'h80, 16'h7FFF, 1'b0, '0},
        '{ACT_INSERT, 8'h7F, 16'h0001, 1'b0, '0},
        '{ACT_INSERT, 8'h33, 16'h0000, 1'b0, '0},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b0, '0},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b0, '0},
        '{ACT_RUN,    8'h00, 16'h0000, 1'b0, '0}
    };

    srpt_sorted_priority_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // a job sorts behind every entry with the same time
    function automatic void sorted_insert(input logic [ID_W-1:0] id, input logic [TM_W-1:0] tm);
        t_entry e;
        int     pos;
        e.id = id;
        e.tm = tm;
        pos  = job_queue.size();
        while (pos > 0 && job_queue[pos-1].tm > tm)
            pos--;
        job_queue.insert(pos, e);
    endfunction

    function automatic step_result_t schedule_step(input logic act, input logic [ID_W-1:0] id,
                                                   input logic [TM_W-1:0] tm);
        step_result_t r;
        t_entry       head;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_INSERT) begin
            if (job_queue.size() >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else if (tm == '0)
                r.status = ST_ZERO;
            else
                sorted_insert(id, tm);
        end else if (job_queue.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            head = job_queue.pop_front();
            r.ran_valid  = 1'b1;
            r.ran_id     = head.id;
            r.ran_before = head.tm;
            if (head.tm > 1)
                sorted_insert(head.id, head.tm - TM_W'(1));
            else
                r.finished = 1'b1;
        end
        if (job_queue.size() > 0) begin
            r.head_id   = job_queue[0].id;
            r.head_time = job_queue[0].tm;
        end
        r.count = QCNT_W'(job_queue.size());
        return r;
    endfunction

    task automatic send_action(input logic act, input logic [ID_W-1:0] id,
                               input logic [TM_W-1:0] tm, input logic fixed_exp,
                               input step_result_t fixed_res);
        step_result_t r;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tm, id};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        r = schedule_step(act, id, tm);
        if (fixed_exp)
            r = fixed_res;
        awaited_results.push_back(r);
        actions_sent++;
        if (r.status == ST_FULL)  full_rejects++;
        if (r.status == ST_EMPTY) empty_rejects++;
        if (r.status == ST_ZERO)  zero_rejects++;
        if (r.finished)           jobs_finished++;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on output transfer %0d: %s got 0x%0h expected 0x%0h",
                 results_checked, field, got, want);
        errors++;
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            if (holds_asked != holds_done) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        step_result_t got;
        step_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ran_id     = m_axis_tdata[7:0];
            got.ran_before = m_axis_tdata[23:8];
            got.head_id    = m_axis_tdata[31:24];
            got.head_time  = m_axis_tdata[47:32];
            got.count      = m_axis_tdata[54:48];
            got.ran_valid  = m_axis_tuser[0];
            got.finished   = m_axis_tuser[1];
            got.status     = m_axis_tuser[3:2];
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata[31:0], '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.ran_valid != want.ran_valid)
                    report_mismatch("ran_valid", 32'(got.ran_valid), 32'(want.ran_valid));
                if (got.ran_id != want.ran_id)
                    report_mismatch("ran_id", 32'(got.ran_id), 32'(want.ran_id));
                if (got.ran_before != want.ran_before)
                    report_mismatch("ran_time_before", 32'(got.ran_before),
                                    32'(want.ran_before));
                if (got.finished != want.finished)
                    report_mismatch("finished", 32'(got.finished), 32'(want.finished));
                if (got.head_id != want.head_id)
                    report_mismatch("head_id", 32'(got.head_id), 32'(want.head_id));
                if (got.head_time != want.head_time)
                    report_mismatch("head_time", 32'(got.head_time), 32'(want.head_time));
                if (got.count != want.count)
                    report_mismatch("queue_count", 32'(got.count), 32'(want.count));
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
            results_checked++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic            act;
        logic [ID_W-1:0] jid;
        logic [TM_W-1:0] jtm;
        stim_mode_t      stim_mode;
        int              mix_done;
        int              full_tries;
        int              pick;
        int              run_pct;

        stim_mode  = MODE_MIX;
        full_tries = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_action(dir_rows[i].act, dir_rows[i].id, dir_rows[i].tm,
                        dir_rows[i].fixed_exp, dir_rows[i].res);

        // phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 28 : 0;
            rx_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 28 : 0;
            if (ph == 0 || ph == 2)
                stim_mode = MODE_FILL;
            mix_done = 0;
            while (mix_done < MIX_ITEMS || stim_mode != MODE_MIX) begin
                jid = ID_W'($urandom_range(255));
                jtm = TM_W'($urandom_range(65535));
                case (stim_mode)
                    MODE_FILL: begin
                        act = ACT_INSERT;
                        jtm = ($urandom_range(6) == 0) ? 16'd2 : 16'd1;
                        if (job_queue.size() >= QUEUE_DEPTH) begin
                            if (full_tries[0])
                                jtm = '0;
                            full_tries++;
                            if (full_tries == 4) begin
                                full_tries = 0;
                                stim_mode  = MODE_DRAIN;
                            end
                        end
                    end
                    MODE_DRAIN: begin
                        act = ACT_RUN;
                        if (job_queue.size() == 0 || job_queue[0].tm > 4)
                            stim_mode = MODE_MIX;
                    end
                    default: begin
                        run_pct = (job_queue.size() > 40) ? 75 :
                                  (job_queue.size() < 8)  ? 25 : 50;
                        act  = ($urandom_range(99) < run_pct) ? ACT_RUN : ACT_INSERT;
                        pick = $urandom_range(99);
                        if (pick < 10)
                            jtm = '0;
                        else if (pick < 65)
                            jtm = TM_W'($urandom_range(4, 1));
                        else if (pick < 90)
                            jtm = TM_W'($urandom_range(200, 5));
                        else
                            jtm = TM_W'($urandom_range(65535, 1));
                        mix_done++;
                    end
                endcase
                if (ph == 0 && mix_done == 0 && full_tries == 0 && job_queue.size() == 20)
                    holds_asked <= holds_asked + 1;
                send_action(act, jid, jtm, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d actions over four handshake phases, checked %0d results",
                 actions_sent, results_checked);
        $display("rejects: %0d full, %0d empty, %0d zero time; %0d jobs finished",
                 full_rejects, empty_rejects, zero_rejects, jobs_finished);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/srpt_pkg.sv
src/srpt_sorted_priority_queue_top.sv
tb/tb.sv
